>>> hw/rtl/tcl_pkg.sv
// Shared types and constants for the telemetry calibration and limit check block.
// No dependencies; every other file of the block imports this package.
package tcl_pkg;

	// Field widths
	localparam int SAMPLE_W    = 16;
	localparam int VALUE_W     = 32;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int COEFF_REGS  = 4;
	// Accumulator growth through one multiply-add cell
	localparam int CELL_GROWTH = SAMPLE_W + 1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [VALUE_W-1:0]  value_t;

	// Saturation rails
	localparam value_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam value_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF_0       = 3'd0,
		REG_COEFF_1       = 3'd1,
		REG_COEFF_2       = 3'd2,
		REG_COEFF_3       = 3'd3,
		REG_WARN_LIMITS   = 3'd4,
		REG_CRIT_LIMITS   = 3'd5,
		REG_LIMITS_ENABLE = 3'd6
	} reg_idx_t;

	// Alarm classification codes
	typedef enum logic [1:0] {
		ALARM_NOMINAL  = 2'd0,
		ALARM_WARNING  = 2'd1,
		ALARM_CRITICAL = 2'd2
	} alarm_t;

	// Limit configuration handed to the output stage
	typedef struct packed {
		logic   enable;
		value_t warn_hi;
		value_t warn_lo;
		value_t crit_hi;
		value_t crit_lo;
	} limit_cfg_t;

endpackage

>>> hw/rtl/tcl_ifs.sv
// Valid/ready channel interfaces: sample requests, result requests and register writes.
// Depends on tcl_pkg.
interface tcl_sample_if;
	import tcl_pkg::*;
	logic    valid;
	logic    ready;
	sample_t raw_sample;
	modport source (output valid, output raw_sample, input ready);
	modport sink   (input valid, input raw_sample, output ready);
endinterface

interface tcl_result_if;
	import tcl_pkg::*;
	logic         valid;
	logic         ready;
	value_t       calibrated_value;
	logic [1:0]   alarm_level;
	logic         saturated;
	modport source (output valid, output calibrated_value, output alarm_level,
		output saturated, input ready);
	modport sink   (input valid, input calibrated_value, input alarm_level,
		input saturated, output ready);
endinterface

interface tcl_cfg_if;
	import tcl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/tcl_cell.sv
// One Horner cell: acc_out = acc_in * x + coeff, registered, with its own valid/ready.
// Depends on tcl_pkg.
module tcl_cell #(
	parameter int  ACC_IN_W  = 32,
	localparam int ACC_OUT_W = ACC_IN_W + tcl_pkg::CELL_GROWTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  tcl_pkg::sample_t            in_x,
	input  logic signed [ACC_IN_W-1:0]  in_acc,
	input  tcl_pkg::value_t             coeff,
	output logic                        out_valid,
	input  logic                        out_ready,
	output tcl_pkg::sample_t            out_x,
	output logic signed [ACC_OUT_W-1:0] out_acc
);
	import tcl_pkg::*;

	localparam int PROD_W = ACC_IN_W + SAMPLE_W;

	logic                        valid_q;
	sample_t                     x_q;
	logic signed [ACC_OUT_W-1:0] acc_q;
	logic signed [PROD_W-1:0]    prod;
	logic signed [ACC_OUT_W-1:0] sum;

	// Exact multiply-add, no rounding
	assign prod = in_acc * in_x;
	assign sum  = ACC_OUT_W'(prod) + ACC_OUT_W'(coeff);

	// Stage takes a new request when empty or when the next cell drains it
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q   <= in_x;
			acc_q <= sum;
		end
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_acc   = acc_q;

endmodule

>>> hw/rtl/tcl_limit.sv
// Output end of the chain: saturation to 32 bits, then alarm classification into the
// output register. Depends on tcl_pkg and tcl_ifs.
module tcl_limit #(
	parameter int ACC_W = 83
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [ACC_W-1:0] in_acc,
	input  tcl_pkg::limit_cfg_t     limits,
	tcl_result_if.source            results
);
	import tcl_pkg::*;

	logic                      valid_s1;
	value_t                    val_s1;
	logic                      sat_s1;
	logic                      valid_s2;
	value_t                    val_s2;
	alarm_t                    alarm_s2;
	logic                      sat_s2;
	logic                      ready_s1;
	logic                      ready_s2;
	logic [ACC_W-VALUE_W:0]    upper;
	logic                      fits;
	value_t                    sat_val;
	alarm_t                    alarm;

	// In range when every bit from the sign of a 32-bit value upward agrees
	assign upper   = in_acc[ACC_W-1:VALUE_W-1];
	assign fits    = (&upper) || !(|upper);
	assign sat_val = fits ? value_t'(in_acc[VALUE_W-1:0])
		: (in_acc[ACC_W-1] ? VALUE_MIN : VALUE_MAX);

	// Critical range first, then warning range; bounds are inclusive
	always_comb begin
		alarm = ALARM_NOMINAL;
		if (limits.enable) begin
			if ($signed(val_s1) < $signed(limits.crit_lo)
				|| $signed(val_s1) > $signed(limits.crit_hi)) begin
				alarm = ALARM_CRITICAL;
			end else if ($signed(val_s1) < $signed(limits.warn_lo)
				|| $signed(val_s1) > $signed(limits.warn_hi)) begin
				alarm = ALARM_WARNING;
			end
		end
	end

	// Two-stage handshake chain
	assign ready_s2 = !valid_s2 || results.ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			val_s1 <= sat_val;
			sat_s1 <= !fits;
		end
		if (valid_s1 && ready_s2) begin
			val_s2   <= val_s1;
			alarm_s2 <= alarm;
			sat_s2   <= sat_s1;
		end
	end

	assign results.valid            = valid_s2;
	assign results.calibrated_value = val_s2;
	assign results.alarm_level      = alarm_s2;
	assign results.saturated        = sat_s2;

endmodule

>>> hw/rtl/telemetry_calibrate_and_limit_check.sv
// Telemetry calibration and limit check: each raw sample x yields one result, the cubic
// c0 + c1*x + c2*x^2 + c3*x^3 evaluated exactly, saturated to signed Q16.16, and
// classified against the critical and warning ranges when limits are enabled. The
// polynomial runs through a chain of Horner multiply-add cells, one per term past the
// first, followed by a saturation stage and a classification stage that is the output
// register. A new sample is taken every cycle while the result side is not stalling; each
// sample passes the cells, then the two output stages. Each stage holds its own request, so
// the chain keeps filling while a finished result waits. Registers are written through
// cfg, which is always ready; write them only while no sample is in flight.
module telemetry_calibrate_and_limit_check #(
	parameter int NUM_TERMS = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tcl_sample_if.sink    samples,
	tcl_result_if.source  results,
	tcl_cfg_if.sink       cfg
);
	import tcl_pkg::*;

	localparam int USED_TERMS = (NUM_TERMS < COEFF_REGS) ? NUM_TERMS : COEFF_REGS;
	localparam int NUM_CELLS  = USED_TERMS - 1;
	localparam int ACC_MAX_W  = VALUE_W + CELL_GROWTH * NUM_CELLS;
	localparam value_t COEFF_1_RESET = value_t'(1) << FRAC_BITS;

	value_t     coeff_q [COEFF_REGS];
	limit_cfg_t limits_q;

	logic                        v_bus   [NUM_CELLS+1];
	logic                        r_bus   [NUM_CELLS+1];
	sample_t                     x_bus   [NUM_CELLS+1];
	logic signed [ACC_MAX_W-1:0] acc_bus [NUM_CELLS+1];

	// Register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < COEFF_REGS; k++) begin
				coeff_q[k] <= (k == 1) ? COEFF_1_RESET : '0;
			end
			limits_q   <= '0;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_COEFF_0: coeff_q[0] <= value_t'(cfg.data[VALUE_W-1:0]);
				REG_COEFF_1: coeff_q[1] <= value_t'(cfg.data[VALUE_W-1:0]);
				REG_COEFF_2: coeff_q[2] <= value_t'(cfg.data[VALUE_W-1:0]);
				REG_COEFF_3: coeff_q[3] <= value_t'(cfg.data[VALUE_W-1:0]);
				REG_WARN_LIMITS: begin
					limits_q.warn_hi <= value_t'(cfg.data[2*VALUE_W-1:VALUE_W]);
					limits_q.warn_lo <= value_t'(cfg.data[VALUE_W-1:0]);
				end
				REG_CRIT_LIMITS: begin
					limits_q.crit_hi <= value_t'(cfg.data[2*VALUE_W-1:VALUE_W]);
					limits_q.crit_lo <= value_t'(cfg.data[VALUE_W-1:0]);
				end
				REG_LIMITS_ENABLE: limits_q.enable <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Head of the chain: highest used coefficient seeds the accumulator
	assign v_bus[0]   = samples.valid;
	assign samples.ready = r_bus[0];
	assign x_bus[0]   = samples.raw_sample;
	assign acc_bus[0] = ACC_MAX_W'(coeff_q[USED_TERMS-1]);

	// Horner cells, each widening the accumulator by one sample width plus carry
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		localparam int IN_W  = VALUE_W + CELL_GROWTH * i;
		localparam int OUT_W = IN_W + CELL_GROWTH;

		logic signed [OUT_W-1:0] cell_acc;

		tcl_cell #(.ACC_IN_W(IN_W)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_bus[i]),
			.in_ready  (r_bus[i]),
			.in_x      (x_bus[i]),
			.in_acc    ($signed(acc_bus[i][IN_W-1:0])),
			.coeff     (coeff_q[USED_TERMS-2-i]),
			.out_valid (v_bus[i+1]),
			.out_ready (r_bus[i+1]),
			.out_x     (x_bus[i+1]),
			.out_acc   (cell_acc)
		);

		assign acc_bus[i+1] = ACC_MAX_W'(cell_acc);
	end

	// Saturation and classification
	tcl_limit #(.ACC_W(ACC_MAX_W)) u_limit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_bus[NUM_CELLS]),
		.in_ready (r_bus[NUM_CELLS]),
		.in_acc   (acc_bus[NUM_CELLS]),
		.limits   (limits_q),
		.results  (results)
	);

endmodule

>>> hw/rtl/tcl_checker.sv
// Port-level checks on the result channel of the calibration block, bound to the top.
// Depends on tcl_pkg.
module tcl_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input tcl_pkg::value_t        res_value,
	input logic [1:0]             res_alarm,
	input logic                   res_sat
);
	import tcl_pkg::*;

	// A stalled result request stays up
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result request dropped while stalled");

	// A clipped result sits on one of the rails
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_sat |-> (res_value == VALUE_MAX) || (res_value == VALUE_MIN))
		else $error("saturated result not at a rail");

	// Pipeline comes out of reset empty
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !res_valid)
		else $error("result valid right after reset");

	// Only the three classification codes appear
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_alarm != 2'd3)
		else $error("undefined alarm level");

endmodule

bind telemetry_calibrate_and_limit_check tcl_checker u_tcl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_value (results.calibrated_value),
	.res_alarm (results.alarm_level),
	.res_sat   (results.saturated)
);

>>> test/tb_telemetry_calibrate_and_limit_check.sv
`timescale 1ns / 100ps
// Testbench for telemetry_calibrate_and_limit_check: directed and random samples over the
// valid/ready channels, every result checked against an exact polynomial predictor.
// Depends on tcl_pkg, the channel interfaces in tcl_ifs and the block itself.

module tb_telemetry_calibrate_and_limit_check;
	import tcl_pkg::*;

	localparam int LATENCY       = 5;
	localparam int HOLD_CYCLES   = 200;
	localparam int DRAIN_CYCLES  = 2000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_SAMPLES = 88;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam value_t ONE = 32'sd65536;

	// Wide enough to hold c3 * x^3 plus the other terms without loss
	typedef logic signed [127:0] exact_t;

	typedef struct packed {
		value_t value;
		alarm_t alarm;
		logic   sat;
	} calib_result_t;

	// Mirror of the register file, exact polynomial predictor and result queue
	class calib_checker;
		value_t        coeff[COEFF_REGS];
		value_t        warn_lo, warn_hi, crit_lo, crit_hi;
		logic          limits_on;
		calib_result_t expected_results[$];
		int            mismatches;

		function new();
			coeff[0]   = '0;
			coeff[1]   = ONE;
			coeff[2]   = '0;
			coeff[3]   = '0;
			warn_lo    = '0;
			warn_hi    = '0;
			crit_lo    = '0;
			crit_hi    = '0;
			limits_on  = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_COEFF_0, REG_COEFF_1, REG_COEFF_2, REG_COEFF_3: begin
					coeff[idx[1:0]] = data[VALUE_W-1:0];
				end
				REG_WARN_LIMITS: begin
					warn_hi = data[63:32];
					warn_lo = data[31:0];
				end
				REG_CRIT_LIMITS: begin
					crit_hi = data[63:32];
					crit_lo = data[31:0];
				end
				REG_LIMITS_ENABLE: begin
					limits_on = data[0];
				end
				default: begin
					// unmapped index, dropped
				end
			endcase
		endfunction

		// Exact cubic, clip to signed 32 bits, then critical before warning
		function void take_sample(sample_t x);
			exact_t        xw, poly;
			value_t        val;
			calib_result_t r;
			xw   = x;
			poly = exact_t'(coeff[0]) + coeff[1] * xw + coeff[2] * xw * xw
				+ coeff[3] * xw * xw * xw;
			r.sat = 1'b0;
			if (poly > exact_t'(VALUE_MAX)) begin
				val   = VALUE_MAX;
				r.sat = 1'b1;
			end else if (poly < exact_t'(VALUE_MIN)) begin
				val   = VALUE_MIN;
				r.sat = 1'b1;
			end else begin
				val = poly[VALUE_W-1:0];
			end
			r.value = val;
			r.alarm = ALARM_NOMINAL;
			if (limits_on) begin
				if (val < crit_lo || val > crit_hi)
					r.alarm = ALARM_CRITICAL;
				else if (val < warn_lo || val > warn_hi)
					r.alarm = ALARM_WARNING;
			end
			expected_results.insert(expected_results.size(), r);
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(value_t v, logic [1:0] a, logic s);
			calib_result_t e;
			if (expected_results.size() == 0) begin
				report($sformatf("result with nothing pending: value=%h alarm=%0d sat=%b",
					v, a, s));
				return;
			end
			e = expected_results.pop_front();
			if (v !== e.value)
				report($sformatf("calibrated_value %h, expected %h", v, e.value));
			if (a !== e.alarm)
				report($sformatf("alarm_level %0d, expected %0d", a, e.alarm));
			if (s !== e.sat)
				report($sformatf("saturated %b, expected %b", s, e.sat));
		endtask

		function int pending();
			return expected_results.size();
		endfunction

		task close_out();
			if (pending() != 0)
				report($sformatf("%0d results never arrived", pending()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   snd_idle = 1'b1;
	bit   rcv_idle = 1'b1;
	bit   hold_request = 1'b0;

	calib_checker sb = new();

	tcl_sample_if smp();
	tcl_result_if res();
	tcl_cfg_if    cfg_ch();

	telemetry_calibrate_and_limit_check i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp),
		.results (res),
		.cfg     (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial begin : watchdog
		#2_000_000;
		$display("telemetry_calibrate_and_limit_check verification failed");
		$finish;
	end

	function automatic value_t rand_signed(int bits);
		value_t r;
		r = $urandom;
		return r >>> (VALUE_W - bits);
	endfunction

	// {high, low}; mostly ordered, sometimes inverted or full scale
	function automatic logic [63:0] pick_range(int bits);
		value_t a, b;
		a = rand_signed(bits);
		b = rand_signed(bits);
		case ($urandom_range(0, 9))
			0: return {VALUE_MAX, VALUE_MIN};
			1: return (a > b) ? {b, a} : {a, b};
			default: return (a > b) ? {a, b} : {b, a};
		endcase
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, data);
		@(negedge clk) cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_sample(sample_t x);
		int gap;
		gap = snd_idle ? $urandom_range(0, 11) : 0;
		repeat (gap) begin
			@(negedge clk);
			smp.valid <= 1'b0;
		end
		@(negedge clk);
		smp.valid      <= 1'b1;
		smp.raw_sample <= x;
		do @(posedge clk); while (!smp.ready);
		sb.take_sample(x);
	endtask

	// Block idle: all results in and the pipeline drained before register writes
	task automatic settle();
		@(negedge clk) smp.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Result side: random stalls per request, one long hold-off on demand
	initial begin : result_sink
		int stall;
		res.ready = 1'b0;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					res.ready <= 1'b0;
				end
			end
			stall = rcv_idle ? $urandom_range(0, 11) : 0;
			repeat (stall) begin
				@(negedge clk);
				res.ready <= 1'b0;
			end
			@(negedge clk) res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			sb.check_result(res.calibrated_value, res.alarm_level, res.saturated);
		end
	end

	initial begin : stimulus
		int                    p, i, k, n, bits;
		sample_t               x;
		value_t                c;
		logic [CFG_DATA_W-1:0] data;

		smp.valid      = 1'b0;
		smp.raw_sample = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = '0;
		cfg_ch.data    = '0;
		arst_n         = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Reset coefficients: pass-through, limits off
		send_sample(-32768);
		send_sample(32767);
		send_sample(0);
		send_sample(-1);
		send_sample(1);
		settle();

		// Write to an unmapped index must change nothing
		write_reg(REG_UNMAPPED, '1);
		send_sample(3);
		settle();

		// Warning +-5.0, critical +-10.0; values on a bound are inside
		write_reg(REG_WARN_LIMITS, {value_t'(5 * ONE), value_t'(-5 * ONE)});
		write_reg(REG_CRIT_LIMITS, {value_t'(10 * ONE), value_t'(-10 * ONE)});
		write_reg(REG_LIMITS_ENABLE, 64'd1);
		send_sample(5);
		send_sample(6);
		send_sample(10);
		send_sample(11);
		send_sample(-5);
		send_sample(-6);
		send_sample(-10);
		send_sample(-11);
		settle();

		// Inverted critical range, then inverted warning range inside a full critical one
		write_reg(REG_CRIT_LIMITS, {value_t'(-10 * ONE), value_t'(10 * ONE)});
		send_sample(0);
		settle();
		write_reg(REG_CRIT_LIMITS, {VALUE_MAX, VALUE_MIN});
		write_reg(REG_WARN_LIMITS, {value_t'(-ONE), ONE});
		send_sample(0);
		settle();

		// Edges of the clip: exactly max, one past, and the negative rail
		write_reg(REG_WARN_LIMITS, {VALUE_MAX, VALUE_MIN});
		write_reg(REG_COEFF_0, {32'h0, VALUE_MAX});
		write_reg(REG_COEFF_1, 64'd1);
		send_sample(0);
		send_sample(1);
		send_sample(-1);
		settle();
		write_reg(REG_COEFF_0, {32'h0, VALUE_MIN});
		send_sample(0);
		send_sample(-1);
		settle();

		// Extreme coefficients at extreme samples
		write_reg(REG_COEFF_0, {32'h0, VALUE_MAX});
		write_reg(REG_COEFF_1, {32'h0, VALUE_MAX});
		write_reg(REG_COEFF_2, {32'h0, VALUE_MAX});
		write_reg(REG_COEFF_3, {32'h0, VALUE_MAX});
		send_sample(32767);
		send_sample(-32768);
		settle();
		write_reg(REG_COEFF_0, {32'hFFFF_FFFF, VALUE_MIN});
		write_reg(REG_COEFF_1, {32'hFFFF_FFFF, VALUE_MIN});
		write_reg(REG_COEFF_2, {32'hFFFF_FFFF, VALUE_MIN});
		write_reg(REG_COEFF_3, {32'hFFFF_FFFF, VALUE_MIN});
		send_sample(32767);

		// Random phases, each with a fresh register set
		for (p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			for (k = 0; k < COEFF_REGS; k++) begin
				// scaled so the term stays near the 32-bit range at full-scale x; c3 is clamped to 2 bits and exceeds it
				bits = 33 - 15 * k;
				if (bits > VALUE_W)
					bits = VALUE_W;
				if (bits < 2)
					bits = 2;
				case ($urandom_range(0, 6))
					0: c = $urandom;
					1: c = '0;
					2: c = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
					default: c = rand_signed(bits);
				endcase
				write_reg(reg_idx_t'(REG_COEFF_0 + k), {32'($urandom), c});
			end
			bits = $urandom_range(12, 32);
			write_reg(REG_CRIT_LIMITS, pick_range(bits));
			write_reg(REG_WARN_LIMITS, pick_range(bits - $urandom_range(0, 2)));
			data    = {32'($urandom), 32'($urandom)};
			data[0] = ($urandom_range(0, 3) != 0);
			write_reg(REG_LIMITS_ENABLE, data);

			snd_idle = (p % 4 != 0) && ($urandom_range(0, 3) != 0);
			rcv_idle = (p % 4 != 0) && ($urandom_range(0, 3) != 0);
			// Back-pressure: sink holds off while the source keeps pushing
			if (p == 3) begin
				snd_idle     = 1'b0;
				hold_request = 1'b1;
			end

			for (i = 0; i < PHASE_SAMPLES; i++) begin
				case ($urandom_range(0, 9))
					5, 6, 7: x = sample_t'(int'($urandom_range(0, 511)) - 256);
					8:       x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					9:       x = sample_t'(int'($urandom_range(0, 8)) - 4);
					default: x = sample_t'($urandom);
				endcase
				send_sample(x);
			end
		end

		// Drain with a bound, then let any stray result show up
		@(negedge clk) smp.valid <= 1'b0;
		for (n = 0; n < DRAIN_CYCLES && sb.pending() != 0; n++)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		sb.close_out();

		if (sb.mismatches == 0)
			$display("telemetry_calibrate_and_limit_check verification clean");
		else
			$display("telemetry_calibrate_and_limit_check verification failed");
		$finish;
	end

endmodule
